### rtl/core/assert_macros.svh
// ----------------------------------------------------------------------------
// assertion macros shared by the rtl
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// plain property, clocked on clk, off during reset
`define GTACC_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// implication in the same cycle
`define GTACC_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

`endif

### rtl/core/gtacc_pkg.sv
// ----------------------------------------------------------------------------
// gtacc_pkg
// shared types, codes and fp32 helpers for the 4x4 gemm tile
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
package gtacc_pkg;

  localparam int TILE = 4;
  localparam int COL_W = 2;

  localparam logic [31:0] QNAN = 32'h7FC00000;

  localparam logic OP_ACC   = 1'b0;
  localparam logic OP_FLUSH = 1'b1;

  localparam logic [COL_W-1:0] LAST_COL = COL_W'(TILE - 1);

  // operand class codes for the multiplier
  localparam logic [1:0] CLS_NORM = 2'd0;
  localparam logic [1:0] CLS_ZERO = 2'd1;
  localparam logic [1:0] CLS_INF  = 2'd2;
  localparam logic [1:0] CLS_NAN  = 2'd3;

  typedef struct packed {
    logic acc_we;
    logic acc_clr;
    logic use_c;
  } gtacc_ctl_t;

  // leading zero count of a nonzero 48-bit word
  function automatic logic [5:0] clz48(input logic [47:0] m);
    logic [5:0] lz;
    begin
      lz = 6'd0;
      for (int i = 0; i < 48; i++) begin
        if (m[i]) lz = 6'(47 - i);
      end
      return lz;
    end
  endfunction

  // round to nearest even and pack; m has its leading one at bit 47,
  // ex is the biased exponent of that leading one
  function automatic logic [31:0] round_pack(input logic s, input logic signed [12:0] ex,
                                             input logic [47:0] m);
    logic [5:0]  sh;
    logic [47:0] ms;
    logic        lost;
    logic [23:0] keep;
    logic        g;
    logic        st;
    logic        inc;
    logic [7:0]  ef;
    logic [30:0] mag;
    begin
      sh = 6'd0;
      if (ex >= 13'sd255) begin
        return {s, 8'hFF, 23'd0};
      end
      if (ex >= 13'sd1) begin
        ms   = m;
        lost = 1'b0;
        ef   = ex[7:0];
      end else begin
        if (ex < -13'sd48) sh = 6'd49;
        else sh = 6'(13'sd1 - ex);
        ms   = m >> sh;
        lost = |(m & ~({48{1'b1}} << sh));
        ef   = 8'd0;
      end
      keep = ms[47:24];
      g    = ms[23];
      st   = (|ms[22:0]) | lost;
      inc  = g & (st | keep[0]);
      mag  = {ef, keep[22:0]} + 31'(inc);
      return {s, mag};
    end
  endfunction

endpackage
`default_nettype wire

### rtl/core/gtacc_fmul.sv
// ----------------------------------------------------------------------------
// gtacc_fmul
// two-stage fp32 multiplier: significand product, then normalize and round
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
module gtacc_fmul (
  input  wire logic        clk,
  input  wire logic        en,
  input  wire logic [31:0] a,
  input  wire logic [31:0] b,
  output logic      [31:0] prod
);

  logic [7:0]  ea, eb;
  logic [23:0] ma, mb;
  logic        za, zb, ia, ib, na, nb;
  logic [1:0]  cls_nxt;

  logic               s_r;
  logic [1:0]         cls_r;
  logic [47:0]        p_r;
  logic signed [12:0] e_r;
  logic [31:0]        prod_r;

  logic [5:0]         lz;
  logic [31:0]        prod_nxt;

  always_comb begin
    ea = (a[30:23] == 8'd0) ? 8'd1 : a[30:23];
    eb = (b[30:23] == 8'd0) ? 8'd1 : b[30:23];
    ma = {a[30:23] != 8'd0, a[22:0]};
    mb = {b[30:23] != 8'd0, b[22:0]};
    za = (a[30:0] == 31'd0);
    zb = (b[30:0] == 31'd0);
    ia = (a[30:23] == 8'hFF) && (a[22:0] == 23'd0);
    ib = (b[30:23] == 8'hFF) && (b[22:0] == 23'd0);
    na = (a[30:23] == 8'hFF) && (a[22:0] != 23'd0);
    nb = (b[30:23] == 8'hFF) && (b[22:0] != 23'd0);
    if (na || nb || (ia && zb) || (za && ib)) cls_nxt = gtacc_pkg::CLS_NAN;
    else if (ia || ib) cls_nxt = gtacc_pkg::CLS_INF;
    else if (za || zb) cls_nxt = gtacc_pkg::CLS_ZERO;
    else cls_nxt = gtacc_pkg::CLS_NORM;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s_r   <= a[31] ^ b[31];
      cls_r <= cls_nxt;
      p_r   <= 48'(ma) * 48'(mb);
      e_r   <= $signed({5'd0, ea}) + $signed({5'd0, eb}) - 13'sd127;
    end
  end

  always_comb begin
    lz = gtacc_pkg::clz48(p_r);
    case (cls_r)
      gtacc_pkg::CLS_NAN:  prod_nxt = gtacc_pkg::QNAN;
      gtacc_pkg::CLS_INF:  prod_nxt = {s_r, 8'hFF, 23'd0};
      gtacc_pkg::CLS_ZERO: prod_nxt = {s_r, 31'd0};
      default: prod_nxt = gtacc_pkg::round_pack(s_r,
                            e_r + 13'sd1 - $signed({7'd0, lz}), p_r << lz);
    endcase
  end

  always_ff @(posedge clk) begin
    if (en) prod_r <= prod_nxt;
  end

  assign prod = prod_r;

endmodule
`default_nettype wire

### rtl/core/gtacc_fadd.sv
// ----------------------------------------------------------------------------
// gtacc_fadd
// combinational fp32 adder, round to nearest even
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
module gtacc_fadd (
  input  wire logic [31:0] a,
  input  wire logic [31:0] b,
  output logic      [31:0] sum
);

  logic        na, nb, ia, ib;
  logic        swap;
  logic [31:0] big, sml;
  logic [7:0]  eb_eff, es_eff, d;
  logic [4:0]  sh;
  logic [26:0] mb27, ms27, al;
  logic        st;
  logic [27:0] r;
  logic [5:0]  lz;
  logic [47:0] m;

  always_comb begin
    na   = (a[30:23] == 8'hFF) && (a[22:0] != 23'd0);
    nb   = (b[30:23] == 8'hFF) && (b[22:0] != 23'd0);
    ia   = (a[30:23] == 8'hFF) && (a[22:0] == 23'd0);
    ib   = (b[30:23] == 8'hFF) && (b[22:0] == 23'd0);
    swap = (b[30:0] > a[30:0]);
    big  = swap ? b : a;
    sml  = swap ? a : b;
    eb_eff = (big[30:23] == 8'd0) ? 8'd1 : big[30:23];
    es_eff = (sml[30:23] == 8'd0) ? 8'd1 : sml[30:23];
    d    = eb_eff - es_eff;
    sh   = (d > 8'd31) ? 5'd31 : d[4:0];
    mb27 = {big[30:23] != 8'd0, big[22:0], 3'b000};
    ms27 = {sml[30:23] != 8'd0, sml[22:0], 3'b000};
    al   = ms27 >> sh;
    st   = |(ms27 & ~({27{1'b1}} << sh));
    al[0] = al[0] | st;
    if (big[31] == sml[31]) r = {1'b0, mb27} + {1'b0, al};
    else r = {1'b0, mb27} - {1'b0, al};
    lz   = gtacc_pkg::clz48({r, 20'd0});
    m    = {r, 20'd0} << lz;

    // nan, opposite infinities, infinities, exact zero, then the rounded sum
    if (na || nb || (ia && ib && (a[31] != b[31]))) sum = gtacc_pkg::QNAN;
    else if (ia) sum = a;
    else if (ib) sum = b;
    else if (r == 28'd0) sum = {a[31] & b[31], 31'd0};
    else sum = gtacc_pkg::round_pack(big[31],
                 $signed({5'd0, eb_eff}) + 13'sd1 - $signed({7'd0, lz}), m);
  end

endmodule
`default_nettype wire

### rtl/core/gtacc_lane.sv
// ----------------------------------------------------------------------------
// gtacc_lane
// one tile element: multiplier, adder and accumulator register
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
module gtacc_lane (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  en,
  input  wire logic [31:0]           a,
  input  wire logic [31:0]           b,
  input  wire logic [31:0]           c_old,
  input  wire gtacc_pkg::gtacc_ctl_t ctl,
  output logic      [31:0]           sum
);

  logic [31:0] prod;
  logic [31:0] addend;
  logic [31:0] acc_r;

  gtacc_fmul u_mul (
    .clk  (clk),
    .en   (en),
    .a    (a),
    .b    (b),
    .prod (prod)
  );

  // flush adds the old c value instead of the product
  assign addend = ctl.use_c ? c_old : prod;

  gtacc_fadd u_add (
    .a   (acc_r),
    .b   (addend),
    .sum (sum)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      acc_r <= 32'd0;
    end else if (ctl.acc_clr) begin
      acc_r <= 32'd0;
    end else if (ctl.acc_we) begin
      acc_r <= sum;
    end
  end

endmodule
`default_nettype wire

### rtl/core/gemm_tile_4x4_accumulate.sv
// ----------------------------------------------------------------------------
// gemm_tile_4x4_accumulate
// fp32 4x4 outer-product tile, C += A*B, sixteen multiply-accumulate lanes
// ----------------------------------------------------------------------------
//
//  channel | ports                                   | direction
//  --------+-----------------------------------------+----------
//  in      | in_valid/in_ready, op, column, x0-3,y0-3| request in
//  out     | out_valid/out_ready, r0-3, column, done | request out
//
//  one request per cycle while not frozen; after the input register, product
//  register and rounded product register an accumulate is written into the
//  accumulators, and a flush result lands in the output register at that point.
//  the accumulate loop closes through one combinational fp adder per lane.
//  reset clears the pipeline valids, output valid and all accumulators to +0.
//  the pipeline freezes only while a flush waits at the adder stage and the
//  output register still holds an untaken result.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"
module gemm_tile_4x4_accumulate (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic        in_op,
  input  wire logic [1:0]  in_column,
  input  wire logic [31:0] in_x0,
  input  wire logic [31:0] in_x1,
  input  wire logic [31:0] in_x2,
  input  wire logic [31:0] in_x3,
  input  wire logic [31:0] in_y0,
  input  wire logic [31:0] in_y1,
  input  wire logic [31:0] in_y2,
  input  wire logic [31:0] in_y3,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [31:0]      out_r0,
  output logic [31:0]      out_r1,
  output logic [31:0]      out_r2,
  output logic [31:0]      out_r3,
  output logic [1:0]       out_column,
  output logic             out_tile_done
);

  localparam int T = gtacc_pkg::TILE;

  // pipeline control, stage 1 = input register, stage 3 = adder stage
  logic v1_r, v2_r, v3_r;
  logic op1_r, op2_r, op3_r;
  logic [gtacc_pkg::COL_W-1:0] col1_r, col2_r, col3_r;

  // operands; x travels on as the old c column for flushes
  logic [31:0] x1_r [T];
  logic [31:0] y1_r [T];
  logic [31:0] x2_r [T];
  logic [31:0] x3_r [T];
  logic [31:0] x_in [T];
  logic [31:0] y_in [T];

  logic [31:0] sums [T][T];

  logic        stall, en, fire3, flush3;
  gtacc_pkg::gtacc_ctl_t ctl;

  logic        out_valid_r;
  logic [31:0] r_r [T];
  logic [gtacc_pkg::COL_W-1:0] col_out_r;
  logic        done_r;

  assign x_in = '{in_x0, in_x1, in_x2, in_x3};
  assign y_in = '{in_y0, in_y1, in_y2, in_y3};

  // only a flush needs the output register
  assign flush3   = v3_r && (op3_r == gtacc_pkg::OP_FLUSH);
  assign stall    = flush3 && out_valid_r && !out_ready;
  assign en       = !stall;
  assign in_ready = en;
  assign fire3    = v3_r && en;

  assign ctl.acc_we  = fire3 && (op3_r == gtacc_pkg::OP_ACC);
  assign ctl.acc_clr = fire3 && flush3 && (col3_r == gtacc_pkg::LAST_COL);
  assign ctl.use_c   = (op3_r == gtacc_pkg::OP_FLUSH);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
    end else if (en) begin
      v1_r <= in_valid;
      v2_r <= v1_r;
      v3_r <= v2_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      op1_r  <= in_op;
      col1_r <= in_column;
      op2_r  <= op1_r;
      col2_r <= col1_r;
      op3_r  <= op2_r;
      col3_r <= col2_r;
      for (int i = 0; i < T; i++) begin
        x1_r[i] <= x_in[i];
        y1_r[i] <= y_in[i];
        x2_r[i] <= x1_r[i];
        x3_r[i] <= x2_r[i];
      end
    end
  end

  // sixteen lanes, row i takes x[i], column j takes y[j]
  for (genvar gi = 0; gi < T; gi++) begin : g_row
    for (genvar gj = 0; gj < T; gj++) begin : g_col
      gtacc_lane u_lane (
        .clk   (clk),
        .rst_n (rst_n),
        .en    (en),
        .a     (x1_r[gi]),
        .b     (y1_r[gj]),
        .c_old (x3_r[gi]),
        .ctl   (ctl),
        .sum   (sums[gi][gj])
      );
    end
  end

  // merge: pick the flushed column out of each row
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (fire3 && flush3) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fire3 && flush3) begin
      for (int i = 0; i < T; i++) begin
        r_r[i] <= sums[i][col3_r];
      end
      col_out_r <= col3_r;
      done_r    <= (col3_r == gtacc_pkg::LAST_COL);
    end
  end

  assign out_valid     = out_valid_r;
  assign out_r0        = r_r[0];
  assign out_r1        = r_r[1];
  assign out_r2        = r_r[2];
  assign out_r3        = r_r[3];
  assign out_column    = col_out_r;
  assign out_tile_done = done_r;

  `GTACC_ASSERT(a_rise_from_flush, $rose(out_valid) |-> $past(flush3),
                "result without a flush")
  `GTACC_ASSERT_IMP(a_done_last_col, out_valid && out_tile_done,
                    out_column == gtacc_pkg::LAST_COL, "tile done on wrong column")
  `GTACC_ASSERT_IMP(a_stall_cause, !in_ready, out_valid && !out_ready && flush3,
                    "stall without a blocked flush")

endmodule
`default_nettype wire

### sim/gtacc_checker.sv
// ----------------------------------------------------------------------------
// gtacc_checker
// watches both channels of the 4x4 fp32 gemm tile, predicts every flush
// result from its own accumulator copy and compares it field by field
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
module gtacc_checker (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  input  wire logic        in_ready,
  input  wire logic        in_op,
  input  wire logic [1:0]  in_column,
  input  wire logic [31:0] in_x0,
  input  wire logic [31:0] in_x1,
  input  wire logic [31:0] in_x2,
  input  wire logic [31:0] in_x3,
  input  wire logic [31:0] in_y0,
  input  wire logic [31:0] in_y1,
  input  wire logic [31:0] in_y2,
  input  wire logic [31:0] in_y3,
  input  wire logic        out_valid,
  input  wire logic        out_ready,
  input  wire logic [31:0] out_r0,
  input  wire logic [31:0] out_r1,
  input  wire logic [31:0] out_r2,
  input  wire logic [31:0] out_r3,
  input  wire logic [1:0]  out_column,
  input  wire logic        out_tile_done,
  output int               fail_count,
  output int               flush_pending
);

  typedef struct {
    logic [31:0] r[gtacc_pkg::TILE];
    logic [1:0]  column;
    logic        tile_done;
  } flush_col_t;

  logic [31:0] acc_m[gtacc_pkg::TILE*gtacc_pkg::TILE];
  flush_col_t  col_q[$];

  // binary32 bits to a double, exact
  function automatic real f32_to_real(input logic [31:0] u);
    logic [63:0] b;
    logic [23:0] m;
    int          k;
    begin
      m = {1'b0, u[22:0]};
      if (u[30:23] == 8'hFF) begin
        b = {u[31], 11'h7FF, u[22:0], 29'd0};
      end else if (u[30:0] == 31'd0) begin
        b = {u[31], 63'd0};
      end else if (u[30:23] == 8'd0) begin
        k = 0;
        while (!m[23]) begin
          m = m << 1;
          k++;
        end
        b = {u[31], 11'(1023 - 126 - k), m[22:0], 29'd0};
      end else begin
        b = {u[31], 11'(int'(u[30:23]) - 127 + 1023), u[22:0], 29'd0};
      end
      return $bitstoreal(b);
    end
  endfunction

  // double to binary32 bits, nearest even, nan made quiet canonical
  function automatic logic [31:0] real_to_f32(input real r);
    logic [63:0] b;
    logic [63:0] sig;
    logic [63:0] keep;
    logic        g;
    logic        st;
    int          fe;
    int          sh;
    logic [31:0] mag;
    begin
      b = $realtobits(r);
      if (b[62:52] == 11'h7FF) begin
        return (b[51:0] != 0) ? gtacc_pkg::QNAN : {b[63], 8'hFF, 23'd0};
      end
      if (b[62:52] == 11'd0) return {b[63], 31'd0};
      sig = {11'd0, 1'b1, b[51:0]};
      fe  = int'(b[62:52]) - 1023 + 127;
      if (fe >= 255) return {b[63], 8'hFF, 23'd0};
      sh = (fe >= 1) ? 29 : 29 + 1 - fe;
      if (sh >= 60) return {b[63], 31'd0};
      keep = sig >> sh;
      g    = sig[sh-1];
      st   = |(sig & ((64'd1 << (sh - 1)) - 64'd1));
      if (fe >= 1) mag = {1'b0, 8'(fe), keep[22:0]};
      else mag = {9'd0, keep[22:0]};
      mag = mag + 32'(g & (st | keep[0]));
      if (mag[30:23] == 8'hFF) mag[22:0] = 23'd0;
      return {b[63], mag[30:0]};
    end
  endfunction

  function automatic logic [31:0] f32_mul(input logic [31:0] a, input logic [31:0] b);
    return real_to_f32(f32_to_real(a) * f32_to_real(b));
  endfunction

  function automatic logic [31:0] f32_add(input logic [31:0] a, input logic [31:0] b);
    return real_to_f32(f32_to_real(a) + f32_to_real(b));
  endfunction

  assign flush_pending = col_q.size();

  always @(posedge clk) begin
    logic [31:0] xv[gtacc_pkg::TILE];
    logic [31:0] yv[gtacc_pkg::TILE];
    flush_col_t  exp_c;
    flush_col_t  got;
    int          nfail;
    nfail = 0;
    if (!rst_n) begin
      for (int i = 0; i < gtacc_pkg::TILE*gtacc_pkg::TILE; i++) acc_m[i] = 32'd0;
      col_q.delete();
      fail_count <= 0;
    end else begin
      // result side first: a result never comes from a request of this edge
      if (out_valid && out_ready) begin
        got.r[0] = out_r0;
        got.r[1] = out_r1;
        got.r[2] = out_r2;
        got.r[3] = out_r3;
        got.column = out_column;
        got.tile_done = out_tile_done;
        if (col_q.size() == 0) begin
          $error("unexpected flush result column %0d", out_column);
          nfail++;
        end else begin
          exp_c = col_q.pop_front();
          for (int i = 0; i < gtacc_pkg::TILE; i++) begin
            if (got.r[i] !== exp_c.r[i]) begin
              $error("r%0d expected %h actual %h", i, exp_c.r[i], got.r[i]);
              nfail++;
            end
          end
          if (got.column !== exp_c.column) begin
            $error("out_column expected %0d actual %0d", exp_c.column, got.column);
            nfail++;
          end
          if (got.tile_done !== exp_c.tile_done) begin
            $error("tile_done expected %0d actual %0d", exp_c.tile_done, got.tile_done);
            nfail++;
          end
        end
      end
      if (in_valid && in_ready) begin
        xv = '{in_x0, in_x1, in_x2, in_x3};
        yv = '{in_y0, in_y1, in_y2, in_y3};
        if (in_op == gtacc_pkg::OP_ACC) begin
          for (int i = 0; i < gtacc_pkg::TILE; i++)
            for (int j = 0; j < gtacc_pkg::TILE; j++)
              acc_m[i*gtacc_pkg::TILE+j] = f32_add(acc_m[i*gtacc_pkg::TILE+j],
                                                   f32_mul(xv[i], yv[j]));
        end else begin
          for (int i = 0; i < gtacc_pkg::TILE; i++)
            exp_c.r[i] = f32_add(xv[i], acc_m[i*gtacc_pkg::TILE+int'(in_column)]);
          exp_c.column = in_column;
          exp_c.tile_done = (in_column == gtacc_pkg::LAST_COL);
          col_q.push_back(exp_c);
          if (in_column == gtacc_pkg::LAST_COL)
            for (int i = 0; i < gtacc_pkg::TILE*gtacc_pkg::TILE; i++) acc_m[i] = 32'd0;
        end
      end
      fail_count <= fail_count + nfail;
    end
  end

endmodule
`default_nettype wire

### sim/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// drives directed and random accumulate/flush requests into the fp32 gemm
// tile with random idling on both sides; the checker predicts and compares
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
module tb_top;

  localparam int WATCHDOG_LIMIT = 5000;
  localparam int DRAIN_CYCLES   = 20;
  localparam int RAND_TILES     = 110;

  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_ready;
  logic        in_op;
  logic [1:0]  in_column;
  logic [31:0] in_x0, in_x1, in_x2, in_x3;
  logic [31:0] in_y0, in_y1, in_y2, in_y3;
  logic        out_valid;
  logic        out_ready;
  logic [31:0] out_r0, out_r1, out_r2, out_r3;
  logic [1:0]  out_column;
  logic        out_tile_done;

  int          fail_count;
  int          flush_pending;
  int          idle_cycles;
  bit          calm;          // no idling on either side while set

  gemm_tile_4x4_accumulate u_dut (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .in_op        (in_op),
    .in_column    (in_column),
    .in_x0        (in_x0),
    .in_x1        (in_x1),
    .in_x2        (in_x2),
    .in_x3        (in_x3),
    .in_y0        (in_y0),
    .in_y1        (in_y1),
    .in_y2        (in_y2),
    .in_y3        (in_y3),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .out_r0       (out_r0),
    .out_r1       (out_r1),
    .out_r2       (out_r2),
    .out_r3       (out_r3),
    .out_column   (out_column),
    .out_tile_done(out_tile_done)
  );

  gtacc_checker u_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .in_op        (in_op),
    .in_column    (in_column),
    .in_x0        (in_x0),
    .in_x1        (in_x1),
    .in_x2        (in_x2),
    .in_x3        (in_x3),
    .in_y0        (in_y0),
    .in_y1        (in_y1),
    .in_y2        (in_y2),
    .in_y3        (in_y3),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .out_r0       (out_r0),
    .out_r1       (out_r1),
    .out_r2       (out_r2),
    .out_r3       (out_r3),
    .out_column   (out_column),
    .out_tile_done(out_tile_done),
    .fail_count   (fail_count),
    .flush_pending(flush_pending)
  );

  // clock, 10 ns period
  initial clk = 1'b0;
  always #5 clk = ~clk;

  // result side backpressure, about 30 stalls in a hundred
  always @(posedge clk) begin
    if (!rst_n) out_ready <= 1'b0;
    else out_ready <= calm ? 1'b1 : ($urandom_range(99) >= 30);
  end

  // watchdog: cycles with no request moving on either channel
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready) || !rst_n) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("gemm_tile_4x4_accumulate regression: fail");
        $finish;
      end
    end
  end

  // special binary32 operands
  function automatic logic [31:0] special_f32(input int sel);
    case (sel)
      0: return 32'h00000000;   // +0
      1: return 32'h80000000;   // -0
      2: return 32'h7F800000;   // +inf
      3: return 32'hFF800000;   // -inf
      4: return 32'h7FC00000;   // quiet nan
      5: return 32'h7F800001;   // signaling nan
      6: return 32'h7F7FFFFF;   // largest normal
      7: return 32'h00000001;   // smallest subnormal
      8: return 32'h007FFFFF;   // largest subnormal
      9: return 32'h00800000;   // smallest normal
      10: return 32'h3F800000;  // 1.0
      11: return 32'hBF800000;  // -1.0
      default: return 32'hFFFFFFFF;
    endcase
  endfunction

  // operand mix: mostly moderate magnitudes so tiles stay finite
  function automatic logic [31:0] rand_f32();
    int pick;
    begin
      pick = $urandom_range(99);
      if (pick < 8) return special_f32($urandom_range(12));
      if (pick < 20) return $urandom;
      if (pick < 26) return {1'($urandom), 8'd0, 23'($urandom)};
      return {1'($urandom), 8'($urandom_range(154, 100)), 23'($urandom)};
    end
  endfunction

  // one request; idles first at random, then holds valid until taken
  task automatic send_req(input logic op, input logic [1:0] col,
                          input logic [31:0] xv[gtacc_pkg::TILE],
                          input logic [31:0] yv[gtacc_pkg::TILE]);
    while (!calm && $urandom_range(99) < 30) begin
      in_valid <= 1'b0;
      in_op    <= 1'($urandom);
      @(posedge clk);
    end
    in_valid  <= 1'b1;
    in_op     <= op;
    in_column <= col;
    in_x0 <= xv[0]; in_x1 <= xv[1]; in_x2 <= xv[2]; in_x3 <= xv[3];
    in_y0 <= yv[0]; in_y1 <= yv[1]; in_y2 <= yv[2]; in_y3 <= yv[3];
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  task automatic send_rand(input logic op, input logic [1:0] col);
    logic [31:0] xv[gtacc_pkg::TILE];
    logic [31:0] yv[gtacc_pkg::TILE];
    for (int i = 0; i < gtacc_pkg::TILE; i++) begin
      xv[i] = rand_f32();
      yv[i] = rand_f32();
    end
    send_req(op, col, xv, yv);
  endtask

  // flush the four columns in a random order, column 3 always last
  task automatic flush_tile();
    logic [1:0] order[3];
    logic [1:0] t;
    int         k;
    order = '{2'd0, 2'd1, 2'd2};
    for (int i = 2; i > 0; i--) begin
      k = $urandom_range(i);
      t = order[i]; order[i] = order[k]; order[k] = t;
    end
    for (int i = 0; i < 3; i++) send_rand(gtacc_pkg::OP_FLUSH, order[i]);
    send_rand(gtacc_pkg::OP_FLUSH, gtacc_pkg::LAST_COL);
  endtask

  initial begin
    logic [31:0] xv[gtacc_pkg::TILE];
    logic [31:0] yv[gtacc_pkg::TILE];
    int          nk;
    calm      = 1'b0;
    rst_n     = 1'b0;
    in_valid  = 1'b0;
    in_op     = gtacc_pkg::OP_ACC;
    in_column = 2'd0;
    {in_x0, in_x1, in_x2, in_x3} = '0;
    {in_y0, in_y1, in_y2, in_y3} = '0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: flush of a fresh tile, signed zero against +0 accumulators
    xv = '{32'h80000000, 32'h00000000, 32'h7F7FFFFF, 32'hFFFFFFFF};
    yv = '{32'hFFFFFFFF, 32'hFFFFFFFF, 32'hFFFFFFFF, 32'hFFFFFFFF};
    send_req(gtacc_pkg::OP_FLUSH, 2'd0, xv, yv);
    // directed: special operands crossed; the column field, ignored on accumulate, is 0 on each accumulate here
    for (int s = 0; s < 12; s += 4) begin
      xv = '{special_f32(s), special_f32(s+1), special_f32(s+2), special_f32(s+3)};
      yv = '{special_f32(11-s), special_f32(10-s), special_f32(9-s), special_f32(8-s)};
      send_req(gtacc_pkg::OP_ACC, 2'(s), xv, yv);
      send_req(gtacc_pkg::OP_FLUSH, 2'd1, xv, yv);
    end
    send_req(gtacc_pkg::OP_FLUSH, gtacc_pkg::LAST_COL, xv, yv);
    // directed: overflow to inf, subnormal products and sums, repeat flush
    xv = '{32'h7F7FFFFF, 32'h00000001, 32'h007FFFFF, 32'h3F800000};
    yv = '{32'h7F7FFFFF, 32'h3F000000, 32'h00800000, 32'hFFFFFFFF};
    send_req(gtacc_pkg::OP_ACC, 2'd3, xv, yv);
    send_req(gtacc_pkg::OP_ACC, 2'd0, xv, yv);
    send_req(gtacc_pkg::OP_FLUSH, 2'd2, xv, yv);
    send_req(gtacc_pkg::OP_FLUSH, 2'd2, yv, xv);
    send_req(gtacc_pkg::OP_FLUSH, 2'd0, xv, xv);
    send_req(gtacc_pkg::OP_FLUSH, gtacc_pkg::LAST_COL, yv, yv);
    // inf - inf inside one accumulator makes nan
    xv = '{32'h7F800000, 32'hFF800000, 32'h7F800000, 32'h00000000};
    yv = '{32'h3F800000, 32'h3F800000, 32'hBF800000, 32'h7F800000};
    send_req(gtacc_pkg::OP_ACC, 2'd0, xv, yv);
    send_req(gtacc_pkg::OP_ACC, 2'd0, yv, xv);
    flush_tile();

    // random tiles: a few k steps then the column flushes, with some noise
    for (int n = 0; n < RAND_TILES; n++) begin
      calm = (n >= 40 && n < 55);
      if (n == 70) begin
        // hold the sender until every expected result is back
        in_valid <= 1'b0;
        @(posedge clk);
        while (flush_pending != 0) @(posedge clk);
      end
      nk = $urandom_range(6, 1);
      for (int k = 0; k < nk; k++) send_rand(gtacc_pkg::OP_ACC, 2'($urandom));
      if ($urandom_range(9) == 0) send_rand(gtacc_pkg::OP_FLUSH, 2'($urandom_range(2)));
      if ($urandom_range(4) == 0) send_rand(1'($urandom), 2'($urandom));
      flush_tile();
    end
    calm = 1'b0;

    in_valid <= 1'b0;
    @(posedge clk);
    while (flush_pending != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fail_count == 0) begin
      $display("gemm_tile_4x4_accumulate regression: pass");
    end else begin
      $display("gemm_tile_4x4_accumulate regression: fail");
    end
    $finish;
  end

endmodule
`default_nettype wire
